// ===== rtl/core/sha256bs_pkg.sv =====
package sha256bs_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_item_t;

  // controls from the sequencer to the round datapath
  typedef struct packed {
    logic       load_en;
    logic       round_en;
    logic       rot_en;
    logic       w_from_mem;
    logic [5:0] round_idx;
  } core_ctrl_t;

  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [3:0]  LEN_HI_WORD = 4'd14;
  localparam logic [3:0]  LAST_WORD   = 4'd15;
  localparam logic [5:0]  LAST_ROUND  = 6'd63;
  localparam logic [5:0]  LAST_BYTE   = 6'd63;
  localparam logic [3:0]  CHAIN_SWEEP = 4'd8;
  localparam logic [2:0]  LAST_DIGEST = 3'd7;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  localparam logic [31:0] START_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic logic [31:0] ch(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic logic [31:0] maj(input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

// ===== rtl/core/sha256bs_block_mem.sv =====
module sha256bs_block_mem (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/core/sha256bs_chain_store.sv =====
module sha256bs_chain_store (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic [2:0]  rd_addr,
  input  logic        wr_en,
  input  logic [2:0]  wr_addr,
  input  logic [31:0] wr_data,
  output logic [31:0] rd_word
);
  import sha256bs_pkg::*;

  logic [31:0] mem [8];
  logic [7:0]  valid;
  logic [31:0] rd_q;
  logic        vld_q;
  logic [2:0]  addr_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q   <= mem[rd_addr];
    addr_q <= rd_addr;
  end

  // an entry not yet written since the last digest reads as the initial value
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      vld_q <= valid[rd_addr];
    end
  end

  assign rd_word = vld_q ? rd_q : START_H[addr_q];

endmodule

// ===== rtl/core/sha256bs_round_core.sv =====
module sha256bs_round_core (
  input  logic                     clk,
  input  sha256bs_pkg::core_ctrl_t ctrl,
  input  logic [31:0]              chain_word,
  input  logic [31:0]              block_word,
  output logic [31:0]              work_a
);
  import sha256bs_pkg::*;

  logic [31:0] v  [8];
  logic [31:0] sr [16];
  logic [31:0] w_new;
  logic [31:0] t1;
  logic [31:0] t2;

  assign w_new = ctrl.w_from_mem ? block_word
               : sr[0] + ssig0(sr[1]) + sr[9] + ssig1(sr[14]);
  assign t1 = v[7] + bsig1(v[4]) + ch(v[4], v[5], v[6]) + ROUND_K[ctrl.round_idx] + w_new;
  assign t2 = bsig0(v[0]) + maj(v[0], v[1], v[2]);
  assign work_a = v[0];

  always_ff @(posedge clk) begin
    if (ctrl.round_en) begin
      v[0] <= t1 + t2;
      v[1] <= v[0];
      v[2] <= v[1];
      v[3] <= v[2];
      v[4] <= v[3] + t1;
      v[5] <= v[4];
      v[6] <= v[5];
      v[7] <= v[6];
      for (int i = 0; i < 15; i++) begin
        sr[i] <= sr[i+1];
      end
      sr[15] <= w_new;
    end else if (ctrl.load_en || ctrl.rot_en) begin
      // shift toward a; load takes chaining words, rotate hands a back to h
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i+1];
      end
      v[7] <= ctrl.load_en ? chain_word : v[0];
    end
  end

endmodule

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// Bytes enter at one per cycle while the block buffer fills; no byte is taken while busy.
// Each full 64-byte block then runs the compression loop: a sweep reading the chaining
// memory, 64 rounds of the shared round unit, then a sweep adding back into that memory.
// The final beat adds padding writes and one or two compressions, then eight digest beats,
// each a chaining memory read followed by the word being held until it is taken.
// Reset (synchronous, active high) restores the initial hash values and a zero bit count.
module sha256_byte_stream_hasher (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       byte_valid,
  output logic                       byte_ready,
  input  sha256bs_pkg::byte_item_t   byte_item,
  output logic                       digest_valid,
  input  logic                       digest_ready,
  output sha256bs_pkg::digest_item_t digest_item
);
  import sha256bs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD_HEAD, ST_PAD_ZERO, ST_DIG_RD, ST_DIG_OUT
  } state_t;

  state_t      state;
  logic [3:0]  cnt;
  logic [5:0]  rnd;
  logic [3:0]  wp;
  logic [2:0]  idx;
  logic [63:0] bit_count;
  logic [23:0] acc;
  logic        pend_end;
  logic        in_pad;
  logic        len_here;
  logic        dig_load;

  logic [5:0]  pos;
  logic        take;
  logic [31:0] head_word;
  logic        bw_en;
  logic [3:0]  bw_addr;
  logic [31:0] bw_data;
  logic [3:0]  br_addr;
  logic [31:0] block_word;
  logic [2:0]  cr_addr;
  logic        cw_en;
  logic [2:0]  cw_addr;
  logic [31:0] chain_word;
  logic [31:0] work_a;
  logic        chain_clear;
  core_ctrl_t  ctrl;

  assign pos        = bit_count[8:3];
  assign byte_ready = (state == ST_IDLE);
  assign take       = byte_valid && byte_ready;

  always_comb begin
    unique case (pos[1:0])
      2'd0: head_word = {PAD_BYTE, 24'd0};
      2'd1: head_word = {acc[7:0], PAD_BYTE, 16'd0};
      2'd2: head_word = {acc[15:0], PAD_BYTE, 8'd0};
      2'd3: head_word = {acc[23:0], PAD_BYTE};
      default: head_word = '0;
    endcase
  end

  always_comb begin
    bw_en   = 1'b0;
    bw_addr = pos[5:2];
    bw_data = {acc, byte_item.data_byte};
    unique case (state)
      ST_IDLE: bw_en = take && byte_item.has_byte && (pos[1:0] == 2'b11);
      ST_PAD_HEAD: begin
        bw_en   = 1'b1;
        bw_data = head_word;
      end
      ST_PAD_ZERO: begin
        bw_en   = 1'b1;
        bw_addr = wp;
        if (len_here && wp == LEN_HI_WORD) begin
          bw_data = bit_count[63:32];
        end else if (len_here && wp == LAST_WORD) begin
          bw_data = bit_count[31:0];
        end else begin
          bw_data = '0;
        end
      end
      default: bw_en = 1'b0;
    endcase
  end

  assign br_addr = (state == ST_ROUND) ? rnd[3:0] + 4'd1 : '0;
  assign cr_addr = (state == ST_DIG_RD || state == ST_DIG_OUT) ? idx : cnt[2:0];
  assign cw_en   = (state == ST_ADD) && (cnt != '0);
  assign cw_addr = cnt[2:0] - 3'd1;
  assign chain_clear = (state == ST_DIG_OUT) && digest_ready && (idx == LAST_DIGEST);

  always_comb begin
    ctrl.load_en    = (state == ST_LOAD) && (cnt != '0);
    ctrl.round_en   = (state == ST_ROUND);
    ctrl.rot_en     = cw_en;
    ctrl.w_from_mem = (rnd[5:4] == 2'b00);
    ctrl.round_idx  = rnd;
  end

  sha256bs_block_mem u_block (
    .clk     (clk),
    .wr_en   (bw_en),
    .wr_addr (bw_addr),
    .wr_data (bw_data),
    .rd_addr (br_addr),
    .rd_data (block_word)
  );

  sha256bs_chain_store u_chain (
    .clk     (clk),
    .rst     (rst),
    .clear   (chain_clear),
    .rd_addr (cr_addr),
    .wr_en   (cw_en),
    .wr_addr (cw_addr),
    .wr_data (chain_word + work_a),
    .rd_word (chain_word)
  );

  sha256bs_round_core u_core (
    .clk        (clk),
    .ctrl       (ctrl),
    .chain_word (chain_word),
    .block_word (block_word),
    .work_a     (work_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      rnd          <= '0;
      wp           <= '0;
      idx          <= '0;
      bit_count    <= '0;
      pend_end     <= 1'b0;
      in_pad       <= 1'b0;
      len_here     <= 1'b0;
      dig_load     <= 1'b0;
      digest_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            cnt <= '0;
            if (byte_item.has_byte) begin
              bit_count <= bit_count + BITS_PER_BYTE;
              acc       <= {acc[15:0], byte_item.data_byte};
              if (pos == LAST_BYTE) begin
                pend_end <= byte_item.end_of_message;
                state    <= ST_LOAD;
              end else if (byte_item.end_of_message) begin
                state <= ST_PAD_HEAD;
              end
            end else if (byte_item.end_of_message) begin
              state <= ST_PAD_HEAD;
            end
          end
        end
        ST_PAD_HEAD: begin
          in_pad   <= 1'b1;
          len_here <= (pos[5:3] != 3'b111);
          wp       <= pos[5:2] + 4'd1;
          cnt      <= '0;
          state    <= (pos[5:2] == LAST_WORD) ? ST_LOAD : ST_PAD_ZERO;
        end
        ST_PAD_ZERO: begin
          wp  <= wp + 4'd1;
          cnt <= '0;
          if (wp == LAST_WORD) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cnt <= cnt + 4'd1;
          if (cnt == CHAIN_SWEEP) begin
            rnd   <= '0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == LAST_ROUND) begin
            cnt   <= '0;
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          cnt <= cnt + 4'd1;
          if (cnt == CHAIN_SWEEP) begin
            if (in_pad) begin
              if (len_here) begin
                idx   <= '0;
                state <= ST_DIG_RD;
              end else begin
                // length goes in a second block of zeros
                len_here <= 1'b1;
                wp       <= '0;
                state    <= ST_PAD_ZERO;
              end
            end else if (pend_end) begin
              pend_end <= 1'b0;
              state    <= ST_PAD_HEAD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_DIG_RD: begin
          dig_load <= 1'b1;
          state    <= ST_DIG_OUT;
        end
        ST_DIG_OUT: begin
          dig_load <= 1'b0;
          if (dig_load) begin
            digest_valid            <= 1'b1;
            digest_item.digest_word <= chain_word;
            digest_item.word_index  <= idx;
            digest_item.final_word  <= (idx == LAST_DIGEST);
          end else if (digest_valid && digest_ready) begin
            digest_valid <= 1'b0;
            if (idx == LAST_DIGEST) begin
              bit_count <= '0;
              in_pad    <= 1'b0;
              len_here  <= 1'b0;
              state     <= ST_IDLE;
            end else begin
              idx   <= idx + 3'd1;
              state <= ST_DIG_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_take_while_digest: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> !byte_ready)
    else $error("byte taken while digest pending");

  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && digest_item.final_word |=> bit_count == '0)
    else $error("bit count not cleared after digest");

  a_round_follows_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD && cnt == CHAIN_SWEEP |=> state == ST_ROUND && rnd == '0)
    else $error("rounds did not start after chain load");

  a_chain_write_only_in_add: assert property (@(posedge clk) disable iff (rst)
    cw_en |-> !bw_en && !digest_valid)
    else $error("chain write overlaps buffer write or digest");

endmodule
